FILE: hw/rtl/ssi_pkg.sv
// Shared types and width constants for the segment versus sphere intersection pipeline.
package ssi_pkg;

  // Field widths
  localparam int unsigned CoordBits = 24;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned QBits     = FracBits + 1;

  // Datapath widths
  localparam int unsigned DiffBits    = CoordBits + 1;       // signed D and O terms
  localparam int unsigned MagBits     = 2 * CoordBits + 2;   // |A|, |b|, |C|
  localparam int unsigned SumBits     = MagBits + 1;         // signed b and C
  localparam int unsigned HalfBits    = (MagBits + 1) / 2;   // partial product operand
  localparam int unsigned ProdBits    = 4 * HalfBits;        // b*b and A*|C|
  localparam int unsigned DiscBits    = ProdBits + 2;        // signed discriminant
  localparam int unsigned SqrtInBits  = DiscBits - 1;
  localparam int unsigned RootShift   = 2 * (FracBits + 1);
  localparam int unsigned XBits       = SqrtInBits + RootShift;
  localparam int unsigned XEvenBits   = XBits + (XBits % 2);
  localparam int unsigned RootBits    = XEvenBits / 2;
  localparam int unsigned RemBits     = RootBits + 3;
  localparam int unsigned KbBits      = SumBits + FracBits + 1;
  localparam int unsigned NumBits     =
      ((KbBits > RootBits + 1) ? KbBits : RootBits + 1) + 2;
  localparam int unsigned DenBits     = MagBits + 1;
  localparam int unsigned DivBits     =
      ((NumBits > DenBits + FracBits) ? NumBits : DenBits + FracBits) + 1;

  // Request payload
  typedef struct packed {
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] start_z;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic signed [CoordBits-1:0] end_z;
    logic signed [CoordBits-1:0] center_x;
    logic signed [CoordBits-1:0] center_y;
    logic signed [CoordBits-1:0] center_z;
    logic        [CoordBits-2:0] radius;
  } ssi_req_t;

  // Result payload
  typedef struct packed {
    logic             hit;
    logic             starts_inside;
    logic [QBits-1:0] enter_fraction;
    logic [QBits-1:0] exit_fraction;
  } ssi_res_t;

  // Per-item status carried alongside the root computation
  typedef struct packed {
    logic                      hit;
    logic                      start_in;
    logic                      solvable;
    logic        [MagBits-1:0] a;
    logic signed [SumBits-1:0] b;
  } ssi_side_t;

endpackage

FILE: hw/rtl/ssi_setup.sv
// Three-stage front end: differences, per-axis products, quadratic coefficients.
module ssi_setup (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  ssi_pkg::ssi_req_t                 req_i,
  output logic                              valid_o,
  output logic signed [ssi_pkg::SumBits-1:0] a_o,
  output logic signed [ssi_pkg::SumBits-1:0] b_o,
  output logic signed [ssi_pkg::SumBits-1:0] c_o
);

  localparam int unsigned CW = ssi_pkg::CoordBits;
  localparam int unsigned DW = ssi_pkg::DiffBits;
  localparam int unsigned SW = ssi_pkg::SumBits;
  localparam int unsigned PW = 2 * DW;

  logic signed [CW-1:0] st [3];
  logic signed [CW-1:0] en [3];
  logic signed [CW-1:0] ce [3];

  logic signed [DW-1:0] d_d [3];
  logic signed [DW-1:0] o_d [3];
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] o_q [3];
  logic        [CW-2:0] rad_q;

  logic signed [PW-1:0]   dd_q [3];
  logic signed [PW-1:0]   od_q [3];
  logic signed [PW-1:0]   oo_q [3];
  logic signed [2*CW-1:0] rr_q;

  logic signed [SW-1:0] a_q, b_q, c_q;
  logic v1_q, v2_q, v3_q;

  assign st[0] = req_i.start_x;
  assign st[1] = req_i.start_y;
  assign st[2] = req_i.start_z;
  assign en[0] = req_i.end_x;
  assign en[1] = req_i.end_y;
  assign en[2] = req_i.end_z;
  assign ce[0] = req_i.center_x;
  assign ce[1] = req_i.center_y;
  assign ce[2] = req_i.center_z;

  // D = E - S, O = S - Q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = DW'(en[i]) - DW'(st[i]);
      o_d[i] = DW'(st[i]) - DW'(ce[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]  <= d_d[i];
      o_q[i]  <= o_d[i];
      dd_q[i] <= d_q[i] * d_q[i];
      od_q[i] <= o_q[i] * d_q[i];
      oo_q[i] <= o_q[i] * o_q[i];
    end
    rad_q <= req_i.radius;
    rr_q  <= $signed({1'b0, rad_q}) * $signed({1'b0, rad_q});
    a_q   <= SW'(dd_q[0]) + SW'(dd_q[1]) + SW'(dd_q[2]);
    b_q   <= SW'(od_q[0]) + SW'(od_q[1]) + SW'(od_q[2]);
    c_q   <= SW'(oo_q[0]) + SW'(oo_q[1]) + SW'(oo_q[2]) - SW'(rr_q);
  end

  assign valid_o = v3_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign c_o     = c_q;

endmodule

FILE: hw/rtl/ssi_disc.sv
// Four-stage discriminant b*b - A*C from split partial products, plus hit screening.
module ssi_disc (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [ssi_pkg::SumBits-1:0] a_i,
  input  logic signed [ssi_pkg::SumBits-1:0] b_i,
  input  logic signed [ssi_pkg::SumBits-1:0] c_i,
  output logic                               valid_o,
  output logic [ssi_pkg::SqrtInBits-1:0]     disc_o,
  output ssi_pkg::ssi_side_t                 side_o
);

  localparam int unsigned SW  = ssi_pkg::SumBits;
  localparam int unsigned MW  = ssi_pkg::MagBits;
  localparam int unsigned HW  = ssi_pkg::HalfBits;
  localparam int unsigned HW2 = 2 * HW;
  localparam int unsigned PB  = ssi_pkg::ProdBits;
  localparam int unsigned DB  = ssi_pkg::DiscBits;
  localparam int unsigned EW1 = SW + 1;
  localparam int unsigned EW2 = SW + 2;

  typedef struct packed {
    logic                 a_zero;
    logic                 start_in;
    logic                 miss;
    logic                 c_neg;
    logic        [MW-1:0] a;
    logic signed [SW-1:0] b;
  } pre_t;

  logic signed [EW1-1:0] ba_w;
  logic signed [EW2-1:0] cend_w;
  pre_t                  pre_d;
  logic [MW-1:0]         bm_d, cm_d;

  pre_t          pre1_q, pre2_q, pre3_q;
  logic [MW-1:0] bm1_q, cm1_q;
  logic v1_q, v2_q, v3_q, v4_q;

  logic [HW2-1:0] bx, ax, cx;
  logic [HW2-1:0] bb_ll_q, bb_lh_q, bb_hh_q;
  logic [HW2-1:0] ac_ll_q, ac_lh_q, ac_hl_q, ac_hh_q;
  logic [PB-1:0]  bsq_q, acp_q;

  logic signed [DB-1:0]  dsum_w;
  ssi_pkg::ssi_side_t    side_d, side_q;
  logic [DB-2:0]         disc_q;

  // magnitudes and early-out tests on the roots
  always_comb begin
    ba_w   = EW1'(b_i) + EW1'(a_i);
    cend_w = EW2'(c_i) + EW2'(a_i) + (EW2'(b_i) <<< 1);
    bm_d   = b_i[SW-1] ? MW'(-b_i) : MW'(b_i);
    cm_d   = c_i[SW-1] ? MW'(-c_i) : MW'(c_i);
    pre_d.a_zero   = (a_i == '0);
    pre_d.start_in = c_i[SW-1] || (c_i == '0);
    pre_d.miss     = (!b_i[SW-1] && (b_i != '0) && !c_i[SW-1] && (c_i != '0))
                  || (ba_w[EW1-1] && !cend_w[EW2-1] && (cend_w != '0));
    pre_d.c_neg    = c_i[SW-1];
    pre_d.a        = MW'(a_i);
    pre_d.b        = b_i;
  end

  // operand halves
  assign bx = HW2'(bm1_q);
  assign ax = HW2'(pre1_q.a);
  assign cx = HW2'(cm1_q);

  // final discriminant and hit decision
  always_comb begin
    dsum_w = pre3_q.c_neg ? (DB'(bsq_q) + DB'(acp_q)) : (DB'(bsq_q) - DB'(acp_q));
    side_d.solvable = !pre3_q.a_zero && !pre3_q.miss && !dsum_w[DB-1];
    side_d.hit      = pre3_q.a_zero ? pre3_q.start_in : side_d.solvable;
    side_d.start_in = pre3_q.start_in;
    side_d.a        = pre3_q.a;
    side_d.b        = pre3_q.b;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    pre1_q  <= pre_d;
    bm1_q   <= bm_d;
    cm1_q   <= cm_d;
    pre2_q  <= pre1_q;
    bb_ll_q <= bx[HW-1:0]   * bx[HW-1:0];
    bb_lh_q <= bx[HW-1:0]   * bx[HW2-1:HW];
    bb_hh_q <= bx[HW2-1:HW] * bx[HW2-1:HW];
    ac_ll_q <= ax[HW-1:0]   * cx[HW-1:0];
    ac_lh_q <= ax[HW-1:0]   * cx[HW2-1:HW];
    ac_hl_q <= ax[HW2-1:HW] * cx[HW-1:0];
    ac_hh_q <= ax[HW2-1:HW] * cx[HW2-1:HW];
    pre3_q  <= pre2_q;
    bsq_q   <= {bb_hh_q, bb_ll_q} + (PB'(bb_lh_q) << (HW + 1));
    acp_q   <= {ac_hh_q, ac_ll_q} + (PB'(ac_lh_q) << HW) + (PB'(ac_hl_q) << HW);
    disc_q  <= dsum_w[DB-2:0];
    side_q  <= side_d;
  end

  assign valid_o = v4_q;
  assign disc_o  = disc_q;
  assign side_o  = side_q;

endmodule

FILE: hw/rtl/ssi_sqrt.sv
// Pipelined restoring square root of disc * 4^(FracBits+1), one root bit per stage.
module ssi_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [ssi_pkg::SqrtInBits-1:0] disc_i,
  input  ssi_pkg::ssi_side_t            side_i,
  output logic                          valid_o,
  output logic [ssi_pkg::RootBits-1:0]  root_o,
  output logic                          exact_o,
  output ssi_pkg::ssi_side_t            side_o
);

  localparam int unsigned RB  = ssi_pkg::RootBits;
  localparam int unsigned RMB = ssi_pkg::RemBits;
  localparam int unsigned XIB = ssi_pkg::SqrtInBits;
  localparam int unsigned XEB = ssi_pkg::XEvenBits;
  localparam int unsigned RS  = ssi_pkg::RootShift;

  logic               v_q    [RB];
  logic [RMB-1:0]     rem_q  [RB];
  logic [RB-1:0]      root_q [RB];
  logic [XIB-1:0]     disc_q [RB];
  ssi_pkg::ssi_side_t side_q [RB];

  for (genvar j = 0; j < RB; j++) begin : g_stage
    logic               v_in;
    logic [RMB-1:0]     rem_in;
    logic [RB-1:0]      root_in;
    logic [XIB-1:0]     disc_in;
    ssi_pkg::ssi_side_t side_in;
    logic [XEB-1:0]     x_w;
    logic [RMB-1:0]     rem_s, trial, rem_d;
    logic [RB-1:0]      root_d;
    logic               ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign disc_in = disc_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign disc_in = disc_q[j-1];
      assign side_in = side_q[j-1];
    end

    // bring down the next bit pair and try the next root bit
    assign x_w    = XEB'({disc_in, {RS{1'b0}}});
    assign rem_s  = {rem_in[RMB-3:0], x_w[XEB-1-2*j -: 2]};
    assign trial  = RMB'({root_in, 2'b01});
    assign ge     = (rem_s >= trial);
    assign rem_d  = ge ? (rem_s - trial) : rem_s;
    assign root_d = {root_in[RB-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= rem_d;
      root_q[j] <= root_d;
      disc_q[j] <= disc_in;
      side_q[j] <= side_in;
    end
  end

  assign valid_o = v_q[RB-1];
  assign root_o  = root_q[RB-1];
  assign exact_o = (rem_q[RB-1] == '0);
  assign side_o  = side_q[RB-1];

endmodule

FILE: hw/rtl/ssi_div.sv
// Pipelined clamped fraction floor(num / den), saturation check then one quotient bit per stage.
module ssi_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic                              force_i,
  input  logic signed [ssi_pkg::NumBits-1:0] num_i,
  input  logic [ssi_pkg::DenBits-1:0]       den_i,
  output logic                              valid_o,
  output logic [ssi_pkg::QBits-1:0]         quot_o
);

  localparam int unsigned FB  = ssi_pkg::FracBits;
  localparam int unsigned QB  = ssi_pkg::QBits;
  localparam int unsigned NB  = ssi_pkg::NumBits;
  localparam int unsigned DNB = ssi_pkg::DenBits;
  localparam int unsigned DVB = ssi_pkg::DivBits;
  localparam logic [QB-1:0] Lim = {1'b1, {FB{1'b0}}};

  logic           v_q    [FB+1];
  logic           zero_q [FB+1];
  logic           sat_q  [FB+1];
  logic [DVB-1:0] rem_q  [FB+1];
  logic [DNB-1:0] den_q  [FB+1];
  logic [FB-1:0]  quo_q  [FB+1];

  logic [DVB-1:0] nu_w;

  assign nu_w = DVB'($unsigned(num_i));

  // entry stage: sign and saturation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= force_i || num_i[NB-1];
    sat_q[0]  <= (nu_w >= (DVB'(den_i) << FB));
    rem_q[0]  <= nu_w;
    den_q[0]  <= den_i;
    quo_q[0]  <= '0;
  end

  // restoring steps, most significant quotient bit first
  for (genvar j = 1; j <= FB; j++) begin : g_stage
    logic [DVB-1:0] dsh;
    logic           ge;

    assign dsh = DVB'(den_q[j-1]) << (FB - j);
    assign ge  = (rem_q[j-1] >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[j] <= zero_q[j-1];
      sat_q[j]  <= sat_q[j-1];
      rem_q[j]  <= ge ? (rem_q[j-1] - dsh) : rem_q[j-1];
      den_q[j]  <= den_q[j-1];
      quo_q[j]  <= quo_q[j-1] | (FB'(ge) << (FB - j));
    end
  end

  assign valid_o = v_q[FB];
  assign quot_o  = zero_q[FB] ? '0 : (sat_q[FB] ? Lim : {1'b0, quo_q[FB]});

endmodule

FILE: hw/rtl/segment_sphere_intersect_unit.sv
// Segment versus sphere intersection: top level of the fully pipelined unit.
// Throughput: one request per cycle; busy_o stays low and results cannot be held off.
// The depth is set by the square root, one root bit per stage, and the fraction dividers.
// Reset clears only the valid bits; payload registers are not reset.
module segment_sphere_intersect_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ssi_pkg::ssi_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output ssi_pkg::ssi_res_t result_o
);

  localparam int unsigned SW  = ssi_pkg::SumBits;
  localparam int unsigned FB  = ssi_pkg::FracBits;
  localparam int unsigned QB  = ssi_pkg::QBits;
  localparam int unsigned NB  = ssi_pkg::NumBits;
  localparam int unsigned DNB = ssi_pkg::DenBits;
  localparam int unsigned RB  = ssi_pkg::RootBits;
  localparam int unsigned XIB = ssi_pkg::SqrtInBits;

  logic                 s_valid;
  logic signed [SW-1:0] s_a, s_b, s_c;

  logic                 d_valid;
  logic [XIB-1:0]       d_disc;
  ssi_pkg::ssi_side_t   d_side;

  logic                 r_valid;
  logic [RB-1:0]        r_root;
  logic                 r_exact;
  ssi_pkg::ssi_side_t   r_side;

  logic                 n_valid_q;
  logic signed [NB-1:0] n1_q, n2_q;
  logic signed [NB-1:0] kb_w, base_w;
  logic [DNB-1:0]       m_q;
  logic                 force1_q, force2_q, hit_q, inside_q;

  logic [FB:0]          hit_dly_q, inside_dly_q;
  logic                 q1_valid;
  logic [QB-1:0]        q1, q2;

  logic                 done_q;
  ssi_pkg::ssi_res_t    result_q;

  // never stalls
  assign busy_o = 1'b0;

  ssi_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .req_i   (req_i),
    .valid_o (s_valid),
    .a_o     (s_a),
    .b_o     (s_b),
    .c_o     (s_c)
  );

  ssi_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .a_i     (s_a),
    .b_i     (s_b),
    .c_i     (s_c),
    .valid_o (d_valid),
    .disc_o  (d_disc),
    .side_o  (d_side)
  );

  ssi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .disc_i  (d_disc),
    .side_i  (d_side),
    .valid_o (r_valid),
    .root_o  (r_root),
    .exact_o (r_exact),
    .side_o  (r_side)
  );

  // root numerators: -k*b + A -/+ r, entry rounded down when the root is inexact
  assign kb_w   = NB'(r_side.b) <<< (FB + 1);
  assign base_w = NB'(r_side.a) - kb_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      n_valid_q <= r_valid;
      done_q    <= q1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q         <= base_w - NB'(r_root) - NB'(!r_exact);
    n2_q         <= base_w + NB'(r_root);
    m_q          <= DNB'({r_side.a, 1'b0});
    force1_q     <= !r_side.solvable || r_side.start_in;
    force2_q     <= !r_side.solvable;
    hit_q        <= r_side.hit;
    inside_q     <= r_side.start_in;
    hit_dly_q    <= {hit_dly_q[FB-1:0], hit_q};
    inside_dly_q <= {inside_dly_q[FB-1:0], inside_q};
  end

  ssi_div u_div_enter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_valid_q),
    .force_i (force1_q),
    .num_i   (n1_q),
    .den_i   (m_q),
    .valid_o (q1_valid),
    .quot_o  (q1)
  );

  ssi_div u_div_exit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_valid_q),
    .force_i (force2_q),
    .num_i   (n2_q),
    .den_i   (m_q),
    .valid_o (),
    .quot_o  (q2)
  );

  // output register
  always_ff @(posedge clk_i) begin
    result_q.hit            <= hit_dly_q[FB];
    result_q.starts_inside  <= inside_dly_q[FB];
    result_q.enter_fraction <= q1;
    result_q.exit_fraction  <= q2;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
